>>> design/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg: shared types and constants for the scan code translator
// Holds the keyboard state record, the result record, scan code names and
// the key translation tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sc2a_pkg;

  // Keyboard state carried from one scan code to the next.
  typedef struct packed {
    logic [7:0] aux;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       caps_on;
    logic       caps_key_down;
    logic       num_on;
    logic       num_key_down;
    logic       prefix_pending;
    logic [2:0] led;
  } sc2a_state_t;

  // One translated word.
  typedef struct packed {
    logic       kind;
    logic [7:0] main_byte;
    logic [7:0] aux_byte;
    logic [2:0] led_bits;
  } sc2a_result_t;

  localparam sc2a_state_t ST_RESET = '{
    aux:            8'h00,
    shift_held:     1'b0,
    ctrl_held:      1'b0,
    alt_held:       1'b0,
    caps_on:        1'b0,
    caps_key_down:  1'b0,
    num_on:         1'b1,
    num_key_down:   1'b0,
    prefix_pending: 1'b0,
    led:            3'd2
  };

  // Result kinds.
  localparam logic KIND_KEY = 1'b0;
  localparam logic KIND_LED = 1'b1;

  // Scan codes with dedicated handling.
  localparam logic [7:0] SC_PREFIX       = 8'hE0;
  localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
  localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
  localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] SC_CAPS_BREAK   = 8'hBA;
  localparam logic [7:0] SC_NUM_MAKE     = 8'h45;
  localparam logic [7:0] SC_NUM_BREAK    = 8'hC5;
  localparam logic [7:0] SC_SPACE        = 8'h39;
  localparam logic [7:0] SC_STAR         = 8'h37;
  localparam logic [7:0] SC_LAST_PRINT   = 8'h35;
  localparam logic [7:0] SC_FIRST_SPEC   = 8'h3B;
  localparam logic [7:0] SC_LAST_SPEC    = 8'h53;

  // Aux byte bit positions.
  localparam int AUX_RSHIFT = 0;
  localparam int AUX_LSHIFT = 1;
  localparam int AUX_RCTRL  = 2;
  localparam int AUX_LCTRL  = 3;
  localparam int AUX_RALT   = 4;
  localparam int AUX_LALT   = 5;
  localparam int AUX_EXT    = 6;
  localparam int AUX_SPEC   = 7;

  // LED bit positions.
  localparam int LED_NUM  = 1;
  localparam int LED_CAPS = 2;

  localparam logic [7:0] MAIN_SPACE      = 8'd32;
  localparam logic [7:0] MAIN_STAR       = 8'd42;
  localparam logic [7:0] MAIN_CTRL_PRINT = 8'd114;
  localparam logic [7:0] CTRL_MASK       = 8'h1F;

  // Printable key tables, indexed by the scan code; entries past 0x35 unused.
  localparam logic [7:0] TAB_LOWER [0:63] = '{
    8'd0, 8'd27, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56,
    8'd57, 8'd48, 8'd45, 8'd61, 8'd8, 8'd9, 8'd113, 8'd119, 8'd101, 8'd114,
    8'd116, 8'd121, 8'd117, 8'd105, 8'd111, 8'd112, 8'd91, 8'd93, 8'd13, 8'd0,
    8'd97, 8'd115, 8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108,
    8'd59, 8'd39, 8'd96, 8'd0, 8'd92, 8'd122, 8'd120, 8'd99, 8'd118, 8'd98,
    8'd110, 8'd109, 8'd44, 8'd46, 8'd47,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [7:0] TAB_UPPER [0:63] = '{
    8'd0, 8'd27, 8'd33, 8'd64, 8'd35, 8'd36, 8'd37, 8'd94, 8'd38, 8'd42,
    8'd40, 8'd41, 8'd95, 8'd43, 8'd8, 8'd15, 8'd81, 8'd87, 8'd69, 8'd82,
    8'd84, 8'd89, 8'd85, 8'd73, 8'd79, 8'd80, 8'd123, 8'd125, 8'd13, 8'd0,
    8'd65, 8'd83, 8'd68, 8'd70, 8'd71, 8'd72, 8'd74, 8'd75, 8'd76,
    8'd58, 8'd34, 8'd126, 8'd0, 8'd124, 8'd90, 8'd88, 8'd67, 8'd86, 8'd66,
    8'd78, 8'd77, 8'd60, 8'd62, 8'd63,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [7:0] TAB_ALT [0:63] = '{
    8'd0, 8'd27, 8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127,
    8'd128, 8'd129, 8'd130, 8'd131, 8'd8, 8'd9, 8'd16, 8'd17, 8'd18, 8'd19,
    8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd91, 8'd93, 8'd13, 8'd0,
    8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38,
    8'd59, 8'd39, 8'd96, 8'd0, 8'd92, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48,
    8'd49, 8'd50, 8'd44, 8'd46, 8'd47,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  // Function and keypad tables, indexed by scan code minus 0x3B.
  localparam logic [7:0] SP_PLAIN [0:31] = '{
    8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65, 8'd66, 8'd67, 8'd68,
    8'd0, 8'd0, 8'd71, 8'd72, 8'd73, 8'd45, 8'd75, 8'd76, 8'd77, 8'd43,
    8'd79, 8'd80, 8'd81, 8'd82, 8'd83,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [7:0] SP_SHIFT [0:31] = '{
    8'd84, 8'd85, 8'd86, 8'd87, 8'd88, 8'd89, 8'd90, 8'd91, 8'd92, 8'd93,
    8'd0, 8'd0, 8'd55, 8'd56, 8'd57, 8'd45, 8'd52, 8'd53, 8'd54, 8'd43,
    8'd49, 8'd50, 8'd51, 8'd48, 8'd46,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [7:0] SP_CTRL [0:31] = '{
    8'd94, 8'd95, 8'd96, 8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103,
    8'd0, 8'd0, 8'd119, 8'd0, 8'd132, 8'd45, 8'd115, 8'd0, 8'd116, 8'd43,
    8'd117, 8'd0, 8'd118, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [7:0] SP_ALT [0:31] = '{
    8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
    8'd113, 8'd0, 8'd0, 8'd71, 8'd72, 8'd73, 8'd45, 8'd75, 8'd76, 8'd77,
    8'd43, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

endpackage

`default_nettype wire

>>> design/sc2a_translate.sv
// ----------------------------------------------------------------------------
// sc2a_translate: single-pass scan code translation logic
// From the current keyboard state and one scan code, forms the next state
// and, when the code produces one, a result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sc2a_translate (
  input  wire logic [7:0]           code,
  input  wire sc2a_pkg::sc2a_state_t st,
  output sc2a_pkg::sc2a_state_t     st_nxt,
  output logic                      res_vld,
  output sc2a_pkg::sc2a_result_t    res
);
  import sc2a_pkg::*;

  logic       ext;
  logic [7:0] aux_v;
  logic [7:0] main_v;
  logic [7:0] lo_ch;
  logic [7:0] up_ch;
  logic [7:0] alt_ch;
  logic [4:0] sp_idx;
  logic [7:0] shifted;

  assign lo_ch   = TAB_LOWER[code[5:0]];
  assign up_ch   = TAB_UPPER[code[5:0]];
  assign alt_ch  = TAB_ALT[code[5:0]];
  assign sp_idx  = 5'(code - SC_FIRST_SPEC);

  // Shift/caps choice: caps lock inverts the case of letters only.
  always_comb begin
    if (st.shift_held) begin
      if (st.caps_on && up_ch >= 8'd65 && up_ch <= 8'd90) begin
        shifted = lo_ch;
      end else begin
        shifted = up_ch;
      end
    end else begin
      if (st.caps_on && lo_ch >= 8'd97 && lo_ch <= 8'd122) begin
        shifted = up_ch;
      end else begin
        shifted = lo_ch;
      end
    end
  end

  always_comb begin
    st_nxt  = st;
    res_vld = 1'b0;
    main_v  = 8'h00;
    ext     = st.prefix_pending;
    aux_v   = st.aux;
    res     = '0;

    if (!st.prefix_pending && code == SC_PREFIX) begin
      st_nxt.prefix_pending = 1'b1;
    end else begin
      st_nxt.prefix_pending = 1'b0;
      aux_v[AUX_EXT] = ext;

      unique case (code)
        SC_ALT_MAKE: begin
          st_nxt.alt_held = 1'b1;
          if (ext) aux_v[AUX_RALT] = 1'b1;
          else     aux_v[AUX_LALT] = 1'b1;
        end
        SC_ALT_BREAK: begin
          st_nxt.alt_held = 1'b0;
          if (ext) aux_v[AUX_RALT] = 1'b0;
          else     aux_v[AUX_LALT] = 1'b0;
        end
        SC_CTRL_MAKE: begin
          st_nxt.ctrl_held = 1'b1;
          if (ext) aux_v[AUX_RCTRL] = 1'b1;
          else     aux_v[AUX_LCTRL] = 1'b1;
        end
        SC_CTRL_BREAK: begin
          st_nxt.ctrl_held = 1'b0;
          if (ext) aux_v[AUX_RCTRL] = 1'b0;
          else     aux_v[AUX_LCTRL] = 1'b0;
        end
        SC_LSHIFT_MAKE: begin
          st_nxt.shift_held  = 1'b1;
          aux_v[AUX_LSHIFT] = 1'b1;
        end
        SC_RSHIFT_MAKE: begin
          st_nxt.shift_held  = 1'b1;
          aux_v[AUX_RSHIFT] = 1'b1;
        end
        SC_LSHIFT_BREAK: begin
          st_nxt.shift_held  = 1'b0;
          aux_v[AUX_LSHIFT] = 1'b0;
        end
        SC_RSHIFT_BREAK: begin
          st_nxt.shift_held  = 1'b0;
          aux_v[AUX_RSHIFT] = 1'b0;
        end
        SC_CAPS_MAKE: begin
          if (!st.caps_key_down) begin
            st_nxt.caps_on       = ~st.caps_on;
            st_nxt.caps_key_down = 1'b1;
            st_nxt.led[LED_CAPS] = ~st.led[LED_CAPS];
            res_vld              = 1'b1;
          end
        end
        SC_CAPS_BREAK: begin
          st_nxt.caps_key_down = 1'b0;
        end
        SC_NUM_MAKE: begin
          if (!st.num_key_down) begin
            st_nxt.num_on       = ~st.num_on;
            st_nxt.num_key_down = 1'b1;
            st_nxt.led[LED_NUM] = ~st.led[LED_NUM];
            res_vld             = 1'b1;
          end
        end
        SC_NUM_BREAK: begin
          st_nxt.num_key_down = 1'b0;
        end
        SC_SPACE: begin
          aux_v[AUX_SPEC] = 1'b0;
          main_v          = MAIN_SPACE;
          res_vld         = 1'b1;
        end
        SC_STAR: begin
          aux_v[AUX_SPEC] = st.ctrl_held;
          main_v          = st.ctrl_held ? MAIN_CTRL_PRINT : MAIN_STAR;
          res_vld         = 1'b1;
        end
        default: begin
          if (code[7]) begin
            res_vld = 1'b0;
          end else if (code <= SC_LAST_PRINT) begin
            res_vld = 1'b1;
            if (st.alt_held) begin
              aux_v[AUX_SPEC] = 1'b1;
              main_v          = alt_ch;
            end else begin
              aux_v[AUX_SPEC] = 1'b0;
              main_v          = st.ctrl_held ? (shifted & CTRL_MASK) : shifted;
            end
          end else if (code >= SC_FIRST_SPEC && code <= SC_LAST_SPEC) begin
            res_vld         = 1'b1;
            aux_v[AUX_SPEC] = 1'b1;
            if (st.alt_held) begin
              main_v = SP_ALT[sp_idx];
            end else if (st.ctrl_held) begin
              main_v = SP_CTRL[sp_idx];
            end else if (st.num_on == st.shift_held || ext) begin
              main_v = SP_PLAIN[sp_idx];
            end else begin
              main_v = SP_SHIFT[sp_idx];
            end
          end
        end
      endcase

      st_nxt.aux = aux_v;
    end

    // A lock toggle is the only source of an LED update word.
    res.kind      = (code == SC_CAPS_MAKE || code == SC_NUM_MAKE) ? KIND_LED : KIND_KEY;
    res.main_byte = main_v;
    res.aux_byte  = st_nxt.aux;
    res.led_bits  = st_nxt.led;
  end

endmodule

`default_nettype wire

>>> design/scan_code_to_ascii_translator_core.sv
// ----------------------------------------------------------------------------
// scan_code_to_ascii_translator_core: set-1 scan code to ASCII translator
// Registers one scan code, translates it against the keyboard state and
// places a key word or an LED update word in the output register.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                  | Moves
//   --------+----------------------------------------+------------------------
//   in      | in_valid, in_ready, in_scan_code       | one raw scan code word
//   out     | out_valid, out_ready, out_result_kind, | one key or LED update
//           | out_main_byte, out_aux_byte,           | word
//           | out_led_bits                           |
//
// One scan code is accepted per cycle unless both registers are full and the
// output word is held. A code waits in the input register until the output
// register has room, is then translated into it and raises out_valid; the word
// leaves when out_ready is high.
// Reset (rst_n low, synchronous) empties both registers and restores the
// keyboard state: num lock on, its LED lit, all modifiers released.
// A held output word stalls the code in the input register and so also blocks
// new codes; a free output slot lets the next code in during the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scan_code_to_ascii_translator_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_scan_code,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_result_kind,
  output logic [7:0]      out_main_byte,
  output logic [7:0]      out_aux_byte,
  output logic [2:0]      out_led_bits
);
  import sc2a_pkg::*;

  // Input register stage.
  logic        in_vld_r;
  logic [7:0]  code_r;

  // Keyboard state, updated when the registered code is translated.
  sc2a_state_t st_r;
  sc2a_state_t st_nxt;

  // Output register stage.
  logic         out_vld_r;
  sc2a_result_t res_r;

  logic         res_vld;
  sc2a_result_t res;
  logic         proc;

  // The registered code is translated once there is room for its word:
  // either the output register is empty or its word leaves this cycle.
  assign proc     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc;

  sc2a_translate u_translate (
    .code    (code_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_r <= in_scan_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // Codes that give no word (prefixes, modifiers, releases) still clear a
  // word that is being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_kind = res_r.kind;
  assign out_main_byte   = res_r.main_byte;
  assign out_aux_byte    = res_r.aux_byte;
  assign out_led_bits    = res_r.led_bits;

`ifndef SYNTH
  // Scroll lock is never toggled.
  a_scroll_dark: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.led[0] == 1'b0)
    else $error("scroll lock LED set");

  // The LED bits mirror the lock flags.
  a_led_tracks_locks: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.led[LED_NUM] == st_r.num_on && st_r.led[LED_CAPS] == st_r.caps_on)
    else $error("LED bits out of step with lock flags");

  // An LED update word carries a zero main byte.
  a_led_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.kind == KIND_LED |-> res_r.main_byte == 8'h00)
    else $error("LED update word with nonzero main byte");

  // A full pipeline with a stalled output takes no new code.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_ready |-> !in_ready)
    else $error("input taken while both stages are blocked");
`endif

endmodule

`default_nettype wire
